// ===== design/traffic_light_pedestrian_priority_assert.svh =====
// Assertion macros shared by the traffic light checker.
`ifndef TRAFFIC_LIGHT_PEDESTRIAN_PRIORITY_ASSERT_SVH
`define TRAFFIC_LIGHT_PEDESTRIAN_PRIORITY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TLPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TLPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tlpp_pkg.sv =====
// Shared types, constants and helpers for the traffic light controller.
`default_nettype none

package tlpp_pkg;

    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;
    localparam int PHASE_W     = 3;
    localparam int BLINK_PAIRS_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE = 3'd4;

    localparam int RST_GREEN  = 4500;
    localparam int RST_YELLOW = 2500;
    localparam int RST_WALK   = 2500;
    localparam int RST_BLINK  = 600;
    localparam int RST_SAMPLE = 500;

    localparam int RST_LEN_A_GREEN  = (RST_GREEN / RST_SAMPLE) * RST_SAMPLE;
    localparam int RST_LEN_A_YELLOW = (RST_YELLOW / RST_SAMPLE) * RST_SAMPLE;

    localparam logic [PHASE_W-1:0] PH_A_GREEN  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_A_YELLOW = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WALK     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BLINK    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_B_GREEN  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_B_YELLOW = 3'd5;

    typedef struct packed {
        logic [TICK_W-1:0] len_a_green;
        logic [TICK_W-1:0] len_a_yellow;
        logic [TICK_W-1:0] len_walk;
        logic [TICK_W-1:0] len_blink;
        logic [TICK_W-1:0] len_b_green;
        logic [TICK_W-1:0] len_b_yellow;
        logic [TICK_W-1:0] sample;
    } tlpp_cfg_t;

    typedef struct packed {
        logic               priority_pending;
        logic [PHASE_W-1:0] phase_now;
        logic               walk_green;
        logic               walk_red;
        logic               b_green;
        logic               b_yellow;
        logic               b_red;
        logic               a_green;
        logic               a_yellow;
        logic               a_red;
    } tlpp_result_t;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== design/tlpp_len_unit.sv =====
// Serial remainder unit: rounds a phase length down to whole sample intervals.
`default_nettype none

module tlpp_len_unit #(
    parameter int RESET_LEN = tlpp_pkg::RST_LEN_A_GREEN
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tlpp_pkg::TICK_W-1:0] dividend,
    input  wire logic [tlpp_pkg::TICK_W-1:0] divisor,
    output logic                             busy,
    output logic [tlpp_pkg::TICK_W-1:0]      len
);

    localparam int W     = tlpp_pkg::TICK_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     len_reg;
    logic [W-1:0]     num_reg;
    logic [W-1:0]     dvd_reg;
    logic [W-1:0]     div_reg;
    logic [W-1:0]     rem_reg;
    logic [W:0]       trial;
    logic [W-1:0]     rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            len_reg  <= W'(RESET_LEN);
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_reg <= 1'b0;
                len_reg  <= num_reg - rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign len  = len_reg;

endmodule

`default_nettype wire

// ===== design/tlpp_core.sv =====
// Phase sequencer: state registers and the per-tick next-state and lamp logic.
`default_nettype none

module tlpp_core #(
    parameter int BLINK_PAIRS = tlpp_pkg::BLINK_PAIRS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic                  pressed,
    input  wire tlpp_pkg::tlpp_cfg_t   cfg,
    output tlpp_pkg::tlpp_result_t     result
);

    localparam int W      = tlpp_pkg::TICK_W;
    localparam int STEP_W = $clog2(BLINK_PAIRS + 1);

    typedef struct packed {
        logic [tlpp_pkg::PHASE_W-1:0] phase;
        logic [W-1:0]                 timer;
        logic [W-1:0]                 stimer;
        logic [STEP_W-1:0]            bstep;
        logic                         flag;
        logic                         wip;
        logic                         wred;
    } st_t;

    st_t state_reg;
    st_t state_next;
    st_t s1;
    st_t s2;
    st_t s3;
    st_t s4;

    function automatic logic [W-1:0] len_of(input logic [tlpp_pkg::PHASE_W-1:0] p,
                                            input tlpp_pkg::tlpp_cfg_t c);
        logic [W-1:0] l;
        unique case (p)
            tlpp_pkg::PH_A_GREEN:  l = c.len_a_green;
            tlpp_pkg::PH_A_YELLOW: l = c.len_a_yellow;
            tlpp_pkg::PH_WALK:     l = c.len_walk;
            tlpp_pkg::PH_BLINK:    l = c.len_blink;
            tlpp_pkg::PH_B_GREEN:  l = c.len_b_green;
            tlpp_pkg::PH_B_YELLOW: l = c.len_b_yellow;
            default:               l = '0;
        endcase
        return l;
    endfunction

    function automatic st_t enter(input st_t s, input logic [tlpp_pkg::PHASE_W-1:0] p);
        st_t r;
        r        = s;
        r.phase  = p;
        r.timer  = '0;
        r.stimer = '0;
        if (p == tlpp_pkg::PH_WALK)
        begin
            r.wred = 1'b0;
        end
        if (p == tlpp_pkg::PH_BLINK)
        begin
            r.wred  = 1'b1;
            r.bstep = '0;
        end
        return r;
    endfunction

    function automatic st_t adv(input st_t s, input logic pr);
        st_t               r;
        logic              fl;
        logic [STEP_W-1:0] nstep;
        r     = s;
        fl    = s.flag | pr;
        nstep = s.bstep + STEP_W'(1);
        unique case (s.phase)
            tlpp_pkg::PH_A_GREEN:
            begin
                r = enter(r, tlpp_pkg::PH_A_YELLOW);
            end
            tlpp_pkg::PH_A_YELLOW:
            begin
                r.flag = fl;
                r.wred = 1'b1;
                r.wip  = fl;
                r      = enter(r, fl ? tlpp_pkg::PH_WALK : tlpp_pkg::PH_B_GREEN);
            end
            tlpp_pkg::PH_WALK:
            begin
                r = enter(r, tlpp_pkg::PH_BLINK);
            end
            tlpp_pkg::PH_BLINK:
            begin
                if (s.wred)
                begin
                    r.wred  = 1'b0;
                    r.timer = '0;
                end
                else
                begin
                    r.bstep = nstep;
                    if (nstep >= STEP_W'(BLINK_PAIRS) || nstep == '0)
                    begin
                        r.flag = 1'b0;
                        r      = enter(r, s.wip ? tlpp_pkg::PH_B_GREEN
                                                : tlpp_pkg::PH_A_GREEN);
                    end
                    else
                    begin
                        r.wred  = 1'b1;
                        r.timer = '0;
                    end
                end
            end
            tlpp_pkg::PH_B_GREEN:
            begin
                r = enter(r, tlpp_pkg::PH_B_YELLOW);
            end
            tlpp_pkg::PH_B_YELLOW:
            begin
                r.wip = 1'b0;
                r     = enter(r, tlpp_pkg::PH_WALK);
            end
            default:
            begin
                r = enter(r, tlpp_pkg::PH_A_GREEN);
            end
        endcase
        return r;
    endfunction

    function automatic st_t step_if_due(input st_t s, input logic pr,
                                        input tlpp_pkg::tlpp_cfg_t c);
        return (s.timer >= len_of(s.phase, c)) ? adv(s, pr) : s;
    endfunction

    // Zero-length street A phases can chain up to three phase changes in one tick.
    always_comb
    begin
        s1 = step_if_due(state_reg, pressed, cfg);
        s2 = step_if_due(s1, pressed, cfg);
        s3 = step_if_due(s2, pressed, cfg);
        s4 = s3;
        if (s3.phase <= tlpp_pkg::PH_A_YELLOW)
        begin
            if (s3.stimer >= cfg.sample)
            begin
                s4.stimer = '0;
            end
            if (s4.stimer == '0 && pressed)
            begin
                s4.flag = 1'b1;
            end
        end
        state_next       = s4;
        state_next.timer = s4.timer + W'(1);
        if (s4.phase <= tlpp_pkg::PH_A_YELLOW)
        begin
            state_next.stimer = s4.stimer + W'(1);
        end
    end

    always_comb
    begin
        result                  = '0;
        result.phase_now        = s4.phase;
        result.priority_pending = s4.flag;
        unique case (s4.phase)
            tlpp_pkg::PH_A_GREEN:
            begin
                result.a_green  = 1'b1;
                result.b_red    = 1'b1;
                result.walk_red = 1'b1;
            end
            tlpp_pkg::PH_A_YELLOW:
            begin
                result.a_yellow = 1'b1;
                result.b_red    = 1'b1;
                result.walk_red = 1'b1;
            end
            tlpp_pkg::PH_WALK:
            begin
                result.a_red      = 1'b1;
                result.b_red      = 1'b1;
                result.walk_green = 1'b1;
            end
            tlpp_pkg::PH_BLINK:
            begin
                result.a_red    = 1'b1;
                result.b_red    = 1'b1;
                result.walk_red = s4.wred;
            end
            tlpp_pkg::PH_B_GREEN:
            begin
                result.a_red    = 1'b1;
                result.b_green  = 1'b1;
                result.walk_red = s4.wred;
            end
            tlpp_pkg::PH_B_YELLOW:
            begin
                result.a_red    = 1'b1;
                result.b_yellow = 1'b1;
                result.walk_red = s4.wred;
            end
            default:
            begin
                result.a_red = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/traffic_light_pedestrian_priority.sv =====
// Top level of the traffic light controller with pedestrian priority button.
//
// Usage: each beat on s_axis is one time tick carrying the active-low button
// level in s_axis_tdata[0]. Every tick yields one beat on m_axis with the lamp
// states, the current phase and the priority flag.
// An input beat reaches the result beat through the input register, then the
// result register. Throughput: one tick per cycle while no cfg pass runs and
// m_axis is not stalled, limited by the single registered pass of the sequencer.
// A stalled m_axis_tready holds the result register; one more tick is still
// taken into the input register, after which s_axis_tready drops.
// The cfg channel writes the five timing registers by index. Each write
// starts a serial remainder pass that rounds the street A lengths to
// whole sample intervals; cfg_ready and s_axis_tready stay low until it ends.
// Reset clears the phase to street A green with all timers at zero and loads
// the default timing registers; no clearing pass is needed.
`default_nettype none

module traffic_light_pedestrian_priority #(
    parameter int BLINK_PAIRS = tlpp_pkg::BLINK_PAIRS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [0] button_level, [7:1] zero
    input  wire logic [tlpp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] a_red, [1] a_yellow, [2] a_green, [3] b_red, [4] b_yellow,
    // [5] b_green, [6] walk_red, [7] walk_green, [10:8] phase_now,
    // [11] priority_pending, [15:12] zero
    output logic [tlpp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tlpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tlpp_pkg::TICK_W-1:0]       cfg_data
);

    localparam int W = tlpp_pkg::TICK_W;

    logic [W-1:0] green_reg;
    logic [W-1:0] yellow_reg;
    logic [W-1:0] walk_reg;
    logic [W-1:0] blink_reg;
    logic [W-1:0] sample_reg;
    logic         start_reg;
    logic         in_valid_reg;
    logic         button_reg;
    logic         out_valid_reg;
    logic [tlpp_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic                   cfg_fire;
    logic                   busy;
    logic                   green_busy;
    logic                   yellow_busy;
    logic [W-1:0]           sample_eff;
    logic [W-1:0]           len_a_green;
    logic [W-1:0]           len_a_yellow;
    logic                   proc;
    tlpp_pkg::tlpp_cfg_t    cfg;
    tlpp_pkg::tlpp_result_t result;

    assign busy          = start_reg | green_busy | yellow_busy;
    assign cfg_ready     = !busy;
    assign cfg_fire      = cfg_valid & cfg_ready;
    assign proc          = in_valid_reg & !busy & (!out_valid_reg | m_axis_tready);
    assign s_axis_tready = !busy & (!in_valid_reg | proc);
    assign sample_eff    = tlpp_pkg::at_least_one(sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg  <= W'(tlpp_pkg::RST_GREEN);
            yellow_reg <= W'(tlpp_pkg::RST_YELLOW);
            walk_reg   <= W'(tlpp_pkg::RST_WALK);
            blink_reg  <= W'(tlpp_pkg::RST_BLINK);
            sample_reg <= W'(tlpp_pkg::RST_SAMPLE);
            start_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_fire;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    tlpp_pkg::CFG_GREEN:  green_reg  <= cfg_data;
                    tlpp_pkg::CFG_YELLOW: yellow_reg <= cfg_data;
                    tlpp_pkg::CFG_WALK:   walk_reg   <= cfg_data;
                    tlpp_pkg::CFG_BLINK:  blink_reg  <= cfg_data;
                    tlpp_pkg::CFG_SAMPLE: sample_reg <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    tlpp_len_unit #(
        .RESET_LEN (tlpp_pkg::RST_LEN_A_GREEN)
    ) u_len_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (green_reg),
        .divisor  (sample_eff),
        .busy     (green_busy),
        .len      (len_a_green)
    );

    tlpp_len_unit #(
        .RESET_LEN (tlpp_pkg::RST_LEN_A_YELLOW)
    ) u_len_yellow (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (yellow_reg),
        .divisor  (sample_eff),
        .busy     (yellow_busy),
        .len      (len_a_yellow)
    );

    always_comb
    begin
        cfg.len_a_green  = len_a_green;
        cfg.len_a_yellow = len_a_yellow;
        cfg.len_walk     = tlpp_pkg::at_least_one(walk_reg);
        cfg.len_blink    = tlpp_pkg::at_least_one(blink_reg);
        cfg.len_b_green  = tlpp_pkg::at_least_one(green_reg);
        cfg.len_b_yellow = tlpp_pkg::at_least_one(yellow_reg);
        cfg.sample       = sample_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready & s_axis_tvalid)
        begin
            button_reg <= s_axis_tdata[0];
        end
    end

    tlpp_core #(
        .BLINK_PAIRS (BLINK_PAIRS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (proc),
        .pressed (!button_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_data_reg <= {4'b0000, result.priority_pending, result.phase_now,
                             result.walk_green, result.walk_red, result.b_green,
                             result.b_yellow, result.b_red, result.a_green,
                             result.a_yellow, result.a_red};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/tlpp_checker.sv =====
// Port-level checker for the traffic light controller, bound to the top level.
`default_nettype none
`include "traffic_light_pedestrian_priority_assert.svh"

module tlpp_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [tlpp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    `TLPP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
    `TLPP_ASSERT_NOW(a_one_lamp, m_axis_tvalid, $onehot(m_axis_tdata[2:0]) && $onehot(m_axis_tdata[5:3]), "street lamps not exactly one per street")
    `TLPP_ASSERT_NOW(a_no_conflict, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[3], "street A released while street B not red")
    `TLPP_ASSERT_NOW(a_walk_safe, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[10:8] == tlpp_pkg::PH_WALK && !m_axis_tdata[6] && m_axis_tdata[0] && m_axis_tdata[3], "pedestrian green outside walk phase")

endmodule

bind traffic_light_pedestrian_priority tlpp_checker u_tlpp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Traffic light controller testbench: directed and random ticks and timing writes, checked by a built-in phase model.
module testbench;
    import tlpp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_TICKS = 1300;
    localparam int HOLD_CYCLES  = 48;
    localparam int PLAN_ROWS    = 41;

    localparam logic [OUT_DATA_W-1:0] LAMPS_RESET = 16'h004C;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [TICK_W-1:0]      val;
        logic                   pinned;
        logic [OUT_DATA_W-1:0]  want;
    } row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TICK_W-1:0]      cfg_data = '0;

    logic                   tick_pinned = 1'b0;
    logic [OUT_DATA_W-1:0]  tick_want = '0;
    bit                     calm = 1'b0;
    bit                     stall_rx = 1'b0;
    int                     errors = 0;

    logic [OUT_DATA_W-1:0]  lamp_queue[$];
    logic [OUT_DATA_W-1:0]  want_word;
    tlpp_result_t           want_r;
    tlpp_result_t           got_r;

    logic [TICK_W-1:0]      len_green;
    logic [TICK_W-1:0]      len_yellow;
    logic [TICK_W-1:0]      len_walk;
    logic [TICK_W-1:0]      len_blink;
    logic [TICK_W-1:0]      len_sample;
    logic [PHASE_W-1:0]     ph;
    logic [16:0]            ph_timer;
    logic [16:0]            smp_timer;
    logic [3:0]             blink_cnt;
    logic                   prio;
    logic                   walk_prio;
    logic                   ped_red;

    row_t plan [PLAN_ROWS] = '{
        '{ROW_TICK, '0, 16'd1, 1'b1, LAMPS_RESET},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLE, 16'd0, 1'b0, '0},
        '{ROW_CFG, CFG_GREEN, 16'd0, 1'b0, '0},
        '{ROW_CFG, CFG_YELLOW, 16'd0, 1'b0, '0},
        '{ROW_CFG, CFG_WALK, 16'd0, 1'b0, '0},
        '{ROW_CFG, CFG_BLINK, 16'd0, 1'b0, '0},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLE, 16'd4, 1'b0, '0},
        '{ROW_CFG, CFG_GREEN, 16'd3, 1'b0, '0},
        '{ROW_CFG, CFG_YELLOW, 16'd9, 1'b0, '0},
        '{ROW_CFG, CFG_WALK, 16'd2, 1'b0, '0},
        '{ROW_CFG, CFG_BLINK, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_CFG, CFG_GREEN, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_YELLOW, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_WALK, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_BLINK, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLE, 16'hFFFF, 1'b0, '0},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_CFG, CFG_GREEN, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '0, 16'd0, 1'b0, '0}
    };

    traffic_light_pedestrian_priority dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned one_if_zero(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void enter_phase(input logic [PHASE_W-1:0] p);
        ph = p;
        ph_timer = '0;
        smp_timer = '0;
        if (p == PH_WALK)
            ped_red = 1'b0;
        if (p == PH_BLINK)
        begin
            ped_red = 1'b1;
            blink_cnt = '0;
        end
    endfunction

    function automatic logic [OUT_DATA_W-1:0] lamps_for_tick(input logic level);
        int unsigned  s;
        int unsigned  len;
        int           n;
        logic         pressed;
        tlpp_result_t r;
        pressed = ~level;
        s = one_if_zero(len_sample);
        for (n = 0; n < 16; n++)
        begin
            case (ph)
                PH_A_GREEN:  len = (len_green / s) * s;
                PH_A_YELLOW: len = (len_yellow / s) * s;
                PH_WALK:     len = one_if_zero(len_walk);
                PH_BLINK:    len = one_if_zero(len_blink);
                PH_B_GREEN:  len = one_if_zero(len_green);
                PH_B_YELLOW: len = one_if_zero(len_yellow);
                default:     len = 0;
            endcase
            if (ph <= PH_B_YELLOW && ph_timer < len)
                break;
            case (ph)
                PH_A_GREEN: enter_phase(PH_A_YELLOW);
                PH_A_YELLOW:
                begin
                    if (pressed)
                        prio = 1'b1;
                    ped_red = 1'b1;
                    walk_prio = prio;
                    enter_phase(prio ? PH_WALK : PH_B_GREEN);
                end
                PH_WALK: enter_phase(PH_BLINK);
                PH_BLINK:
                begin
                    if (ped_red)
                    begin
                        ped_red = 1'b0;
                        ph_timer = '0;
                    end
                    else
                    begin
                        blink_cnt = blink_cnt + 4'd1;
                        if (blink_cnt >= BLINK_PAIRS_DEF || blink_cnt == 0)
                        begin
                            prio = 1'b0;
                            enter_phase(walk_prio ? PH_B_GREEN : PH_A_GREEN);
                        end
                        else
                        begin
                            ped_red = 1'b1;
                            ph_timer = '0;
                        end
                    end
                end
                PH_B_GREEN: enter_phase(PH_B_YELLOW);
                PH_B_YELLOW:
                begin
                    walk_prio = 1'b0;
                    enter_phase(PH_WALK);
                end
                default: enter_phase(PH_A_GREEN);
            endcase
        end
        if (ph <= PH_A_YELLOW)
        begin
            if (smp_timer >= s)
                smp_timer = '0;
            if (smp_timer == 0 && pressed)
                prio = 1'b1;
        end
        r = '0;
        case (ph)
            PH_A_GREEN:
            begin
                r.a_green = 1'b1;
                r.b_red = 1'b1;
                r.walk_red = 1'b1;
            end
            PH_A_YELLOW:
            begin
                r.a_yellow = 1'b1;
                r.b_red = 1'b1;
                r.walk_red = 1'b1;
            end
            PH_WALK:
            begin
                r.a_red = 1'b1;
                r.b_red = 1'b1;
                r.walk_green = 1'b1;
            end
            PH_BLINK:
            begin
                r.a_red = 1'b1;
                r.b_red = 1'b1;
                r.walk_red = ped_red;
            end
            PH_B_GREEN:
            begin
                r.a_red = 1'b1;
                r.b_green = 1'b1;
                r.walk_red = ped_red;
            end
            PH_B_YELLOW:
            begin
                r.a_red = 1'b1;
                r.b_yellow = 1'b1;
                r.walk_red = ped_red;
            end
            default: ;
        endcase
        r.phase_now = ph;
        r.priority_pending = prio;
        ph_timer = ph_timer + 17'd1;
        if (ph <= PH_A_YELLOW)
            smp_timer = smp_timer + 17'd1;
        return OUT_DATA_W'(r);
    endfunction

    function automatic void compare_field(input string name, input int unsigned exp_v,
                                          input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic logic [TICK_W-1:0] pick_len(input int small_max);
        case ($urandom_range(0, 63))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return TICK_W'($urandom_range(1, 65535));
            default: return TICK_W'($urandom_range(1, small_max));
        endcase
    endfunction

    task automatic offer_tick(input logic level, input logic pinned,
                              input logic [OUT_DATA_W-1:0] want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'(level);
        tick_pinned <= pinned;
        tick_want <= want;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (lamp_queue.size() != 0);
    endtask

    task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // predict on input beats, check output beats, track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (lamp_queue.size() == 0)
                begin
                    $display("%0t: result beat %h with nothing expected", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want_word = lamp_queue.pop_front();
                    want_r = tlpp_result_t'(want_word[$bits(tlpp_result_t)-1:0]);
                    got_r = tlpp_result_t'(m_axis_tdata[$bits(tlpp_result_t)-1:0]);
                    compare_field("a_red", want_r.a_red, got_r.a_red);
                    compare_field("a_yellow", want_r.a_yellow, got_r.a_yellow);
                    compare_field("a_green", want_r.a_green, got_r.a_green);
                    compare_field("b_red", want_r.b_red, got_r.b_red);
                    compare_field("b_yellow", want_r.b_yellow, got_r.b_yellow);
                    compare_field("b_green", want_r.b_green, got_r.b_green);
                    compare_field("walk_red", want_r.walk_red, got_r.walk_red);
                    compare_field("walk_green", want_r.walk_green, got_r.walk_green);
                    compare_field("phase_now", want_r.phase_now, got_r.phase_now);
                    compare_field("priority_pending", want_r.priority_pending,
                                  got_r.priority_pending);
                    compare_field("pad", want_word[OUT_DATA_W-1:$bits(tlpp_result_t)],
                                  m_axis_tdata[OUT_DATA_W-1:$bits(tlpp_result_t)]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want_word = lamps_for_tick(s_axis_tdata[0]);
                lamp_queue.push_back(tick_pinned ? tick_want : want_word);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GREEN:  len_green = cfg_data;
                    CFG_YELLOW: len_yellow = cfg_data;
                    CFG_WALK:   len_walk = cfg_data;
                    CFG_BLINK:  len_blink = cfg_data;
                    CFG_SAMPLE: len_sample = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (stall_rx)
            begin
                gap = HOLD_CYCLES;
                stall_rx = 1'b0;
            end
            else
                gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            @(negedge clk);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int i;
        int j;
        int k;
        int burst;
        int sent;
        int round;
        int press_pct;
        len_green = TICK_W'(RST_GREEN);
        len_yellow = TICK_W'(RST_YELLOW);
        len_walk = TICK_W'(RST_WALK);
        len_blink = TICK_W'(RST_BLINK);
        len_sample = TICK_W'(RST_SAMPLE);
        ph = PH_A_GREEN;
        ph_timer = '0;
        smp_timer = '0;
        blink_cnt = '0;
        prio = 1'b0;
        walk_prio = 1'b0;
        ped_red = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_timing(plan[i].idx, plan[i].val);
            end
            else
                offer_tick(plan[i].val[0], plan[i].pinned, plan[i].want);
        end

        sent = 0;
        round = 0;
        while (sent < RANDOM_TICKS)
        begin
            drain_results();
            for (k = CFG_GREEN; k <= CFG_SAMPLE; k++)
                if (round == 0 || $urandom_range(0, 1) == 1)
                    write_timing(CFG_IDX_W'(k), pick_len(k == CFG_SAMPLE ? 5 : 12));
            calm = ($urandom_range(0, 3) == 0);
            press_pct = $urandom_range(0, 60);
            burst = $urandom_range(60, 120);
            for (j = 0; j < burst; j++)
            begin
                // hold the receiver off while ticks keep coming
                if (round == 2 && j == 20)
                    stall_rx = 1'b1;
                offer_tick($urandom_range(1, 100) > press_pct, 1'b0, '0);
            end
            sent += burst;
            round++;
        end

        calm = 1'b0;
        drain_results();
        repeat (8) @(negedge clk);
        if (errors == 0 && lamp_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
